FILE: src/pip_pkg.sv
// pip_pkg: shared types and constants for the point-in-polygon test block
// command codes, vertex layout, controller-to-datapath command and datapath-to-controller status structs
// no dependencies
package pip_pkg;

	localparam int COORD_W = 16;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2
	} command_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} vertex_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic append;
		logic rd_en;
		logic rd_first;
		logic close;
		logic resp_load;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_stat_t;

endpackage

FILE: src/pip_in_if.sv
// pip_in_if: input channel carrying one command transaction
// depends on pip_pkg for the coordinate width
interface pip_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             command;
	logic signed [pip_pkg::COORD_W-1:0]     coord_x;
	logic signed [pip_pkg::COORD_W-1:0]     coord_y;

	modport source (output valid, output command, output coord_x, output coord_y, input ready);
	modport sink (input valid, input command, input coord_x, input coord_y, output ready);
endinterface

FILE: src/pip_out_if.sv
// pip_out_if: result channel carrying one result transaction
// no dependencies
interface pip_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic status;

	modport source (output valid, output inside_res, output status, input ready);
	modport sink (input valid, input inside_res, input status, output ready);
endinterface

FILE: src/pip_dp.sv
// pip_dp: datapath with vertex memory, vertex count, edge crossing pipeline and result registers
// depends on pip_pkg for vertex layout and command/status structs
module pip_dp #(
	parameter int MAX_VERTICES = 64,
	localparam int AW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pip_pkg::dp_cmd_t                     cmd,
	input  logic [AW-1:0]                        rd_addr,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0]   coord_y,
	output logic [CW-1:0]                        count,
	output pip_pkg::dp_stat_t                    stat,
	output logic                                 inside_res,
	output logic                                 status
);

	pip_pkg::vertex_t mem [MAX_VERTICES];

	logic [CW-1:0]     count_q;
	logic              full;
	logic signed [15:0] px_q, py_q;
	pip_pkg::vertex_t  rd_data_s1, prev_q, first_q;
	logic              rd_vld_s1, rd_first_s1, close_s1;

	pip_pkg::vertex_t  va, vb;
	logic              edge_vld;
	logic signed [15:0] xi, yi, xj, yj, xtop, ytop, ybot;
	logic              up, skip, direct, dval, mult;
	logic signed [16:0] dy, dxp, dyp, dxe;
	logic signed [33:0] p1, p2;

	logic              edge_vld_s2, direct_s2, dval_s2, mult_s2, up_s2;
	logic signed [33:0] p1_s2, p2_s2;
	logic signed [34:0] lhs;
	logic              hit;

	logic              parity_q, pend_status_q, inside_q, status_q;

	assign full  = (count_q == CW'(MAX_VERTICES));
	assign count = count_q;
	assign stat  = '{pipe_busy: rd_vld_s1 | close_s1 | edge_vld_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.append && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// vertex memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem[count_q[AW-1:0]] <= '{y: coord_y, x: coord_x};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (rd_vld_s1) begin
			prev_q <= rd_data_s1;
			if (rd_first_s1) begin
				first_q <= rd_data_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			close_s1    <= 1'b0;
			edge_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1   <= cmd.rd_en;
			rd_first_s1 <= cmd.rd_first;
			close_s1    <= cmd.close;
			edge_vld_s2 <= edge_vld;
		end
	end

	// edge classification and cross products
	always_comb begin
		va       = prev_q;
		vb       = close_s1 ? first_q : rd_data_s1;
		edge_vld = (rd_vld_s1 & ~rd_first_s1) | close_s1;
		xi       = va.x;
		yi       = va.y;
		xj       = vb.x;
		yj       = vb.y;
		up       = (yj > yi);
		ytop     = up ? yj : yi;
		xtop     = up ? xj : xi;
		ybot     = up ? yi : yj;
		skip     = (yi == yj) || (yi > py_q && yj > py_q) || (yi < py_q && yj < py_q);
		direct   = !skip && (ytop == py_q);
		dval     = (xtop >= px_q);
		mult     = !skip && !direct && (ybot != py_q);
		dy       = 17'(yj) - 17'(yi);
		dxp      = 17'(xi) - 17'(px_q);
		dyp      = 17'(py_q) - 17'(yi);
		dxe      = 17'(xj) - 17'(xi);
		p1       = 34'(dxp) * 34'(dy);
		p2       = 34'(dyp) * 34'(dxe);
	end

	always_ff @(posedge clk) begin
		direct_s2 <= direct;
		dval_s2   <= dval;
		mult_s2   <= mult;
		up_s2     <= up;
		p1_s2     <= p1;
		p2_s2     <= p2;
	end

	always_comb begin
		lhs = 35'(p1_s2) + 35'(p2_s2);
		if (direct_s2) begin
			hit = dval_s2;
		end else if (mult_s2) begin
			hit = up_s2 ? !lhs[34] : (lhs[34] || (lhs == '0));
		end else begin
			hit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q      <= 1'b0;
			pend_status_q <= 1'b0;
		end else if (cmd.accept) begin
			parity_q      <= 1'b0;
			pend_status_q <= cmd.append & full;
		end else if (edge_vld_s2) begin
			parity_q      <= parity_q ^ hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			inside_q <= parity_q;
			status_q <= pend_status_q;
		end
	end

	assign inside_res = inside_q;
	assign status     = status_q;

endmodule

FILE: src/pip_ctrl.sv
// pip_ctrl: controller state machine sequencing commands, edge reads and result handoff
// depends on pip_pkg for command codes and command/status structs
module pip_ctrl #(
	parameter int MAX_VERTICES = 64,
	localparam int AW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [1:0]        item_command,
	output logic              item_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  logic [CW-1:0]     count,
	input  pip_pkg::dp_stat_t stat,
	output pip_pkg::dp_cmd_t  cmd,
	output logic [AW-1:0]     rd_addr
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_CLOSE = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] rd_idx_q, rd_idx_d;
	logic          res_valid_q;
	logic          acc;
	logic          slot_free;

	assign item_ready = (state_q == ST_IDLE);
	assign acc        = item_valid & item_ready;
	assign slot_free  = !res_valid_q || res_ready;
	assign rd_addr    = rd_idx_q[AW-1:0];
	assign res_valid  = res_valid_q;

	always_comb begin
		state_d = state_q;
		rd_idx_d = rd_idx_q;
		cmd = '0;
		cmd.accept = acc;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_RESP;
					case (item_command)
						pip_pkg::CMD_CLEAR:  cmd.clear = 1'b1;
						pip_pkg::CMD_APPEND: cmd.append = 1'b1;
						pip_pkg::CMD_QUERY: begin
							if (count >= CW'(2)) begin
								state_d  = ST_READ;
								rd_idx_d = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (rd_idx_q == '0);
				rd_idx_d     = rd_idx_q + CW'(1);
				if (rd_idx_q == count - CW'(1)) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (!stat.pipe_busy) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_idx_q <= rd_idx_d;
			if (cmd.resp_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/point_in_polygon_test.sv
// point_in_polygon_test: crossing-parity point-in-polygon test over a stored vertex table
// clear and append go straight to the result handoff state, as does a query with fewer than two vertices
// a query with n >= 2 stored vertices reads every vertex, closes the polygon, then waits for the pipeline
// throughput: one vertex per cycle through the single read port of the vertex memory
// the next transaction is taken once the result enters the output register
// reset clears the vertex count and the control state; the vertex memory is not cleared
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64
) (
	input logic      clk,
	input logic      arst_n,
	pip_in_if.sink   item,
	pip_out_if.source result
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	pip_pkg::dp_cmd_t  cmd;
	pip_pkg::dp_stat_t stat;
	logic [AW-1:0]     rd_addr;
	logic [CW-1:0]     count;
	logic              item_ready;
	logic              res_valid;
	logic              inside_res;
	logic              status;

	pip_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_command (item.command),
		.item_ready   (item_ready),
		.res_valid    (res_valid),
		.res_ready    (result.ready),
		.count        (count),
		.stat         (stat),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	pip_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.coord_x    (item.coord_x),
		.coord_y    (item.coord_y),
		.count      (count),
		.stat       (stat),
		.inside_res (inside_res),
		.status     (status)
	);

	assign item.ready        = item_ready;
	assign result.valid      = res_valid;
	assign result.inside_res = inside_res;
	assign result.status     = status;

endmodule
